// ===== rtl/rcl_pkg.sv =====
// rcl_pkg: types, constants and constant tables for the srgb to cielab converter
// depends on nothing; used by rgb_to_cielab_core
`default_nettype none
package rcl_pkg;

    localparam int OUT_FRAC_BITS = 8;
    localparam int RND_SHIFT     = 24 - OUT_FRAC_BITS;
    localparam int L_MAX_RAW     = 100 * (2 ** OUT_FRAC_BITS);
    localparam int L_MAX         = (L_MAX_RAW > 32767) ? 32767 : L_MAX_RAW;

    // offset 16/116 in q24, rounded half up
    localparam int F_OFFSET      = (2 * (16 * (2 ** 24)) + 116) / 232;
    // reciprocal of 125 for a 28-bit dividend, shift 35
    localparam longint RECIP_125 = 64'd274877907;
    localparam longint LIN_LIMIT = 64'd8856 * 64'd16777216;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic        [14:0] lightness;
        logic signed [15:0] green_red;
        logic signed [15:0] blue_yellow;
    } t_lab;

    typedef logic [255:0][16:0]     t_lin_rom;
    typedef logic [2:0][2:0][19:0]  t_mat;

    // shift-subtract quotient of non-negative constants, table building only
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // quotient rounded half up, non-negative operands
    function automatic longint rdiv(longint num, longint den);
        return longint'(udiv(64'(2 * num + den), 64'(2 * den)));
    endfunction

    // linear value of one srgb code in q16
    function automatic logic [16:0] gamma_expand(int c);
        longint unsigned u;
        longint unsigned v;
        longint unsigned w;
        longint unsigned r;
        longint unsigned cand;
        longint unsigned p;
        longint unsigned one30;
        bit ok;
        one30 = 64'd1 << 30;
        w = 0;
        if (c <= 10) begin
            return 17'(rdiv(longint'(c) * 65536 * 100, 255 * 1292));
        end
        u = longint'(rdiv((64'(1000 * c + 14025)) << 30, 269025));
        v = (u * u) >> 30;
        for (int b = 30; b >= 0; b--) begin
            cand = w | (64'd1 << b);
            if (cand <= one30) begin
                p  = cand;
                ok = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    if (ok) begin
                        p = (p * cand) >> 30;
                        if (p > one30) ok = 1'b0;
                    end
                end
                if (ok && p <= v) w = cand;
            end
        end
        r = (v * w) >> 30;
        return 17'((r + (64'd1 << 13)) >> 14);
    endfunction

    function automatic t_lin_rom build_lin_rom();
        t_lin_rom t;
        for (int i = 0; i < 256; i++) t[i] = gamma_expand(i);
        return t;
    endfunction

    // srgb to xyz rows, each divided by the d65 white, q20
    function automatic t_mat build_mat();
        t_mat m;
        longint num [3][3];
        longint den [3];
        num = '{'{41240, 35760, 18050}, '{2126, 7152, 722}, '{1930, 11920, 95050}};
        den = '{95047, 10000, 108883};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = 20'(rdiv(num[i][j] << 20, den[i]));
        return m;
    endfunction

    localparam t_lin_rom LIN_ROM = build_lin_rom();
    localparam t_mat     MAT     = build_mat();

endpackage
`default_nettype wire

// ===== rtl/rgb_to_cielab_core.sv =====
// rgb_to_cielab_core: fully pipelined srgb (8-bit) to cielab d65 converter
// depends on rcl_pkg for types, the gamma table and the matrix coefficients
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  pixel    | in        | start, busy        | i_pixel (red, green, blue)
//  lab      | out       | o_valid strobe     | o_lab (lightness, a, b)
//
// one beat enters per cycle; busy is held low, the pipe never stops
// the pipe depth is set by the cube root: 25 result bits, each taking
// a square stage and a cube-and-compare stage, plus table, matrix, linear
// segment and output stages
// reset clears the valid chain only; payload registers are not reset
// the receiver cannot stall, so each result shows for exactly one cycle
`default_nettype none
module rgb_to_cielab_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output      logic          busy,
    input  wire rcl_pkg::t_pixel i_pixel,
    output      logic          o_valid,
    output      rcl_pkg::t_lab o_lab
);

    localparam int NBITS = 25;              // cube root result bits
    localparam int LAT   = 3 + 2 * NBITS + 3 + 2;

    logic [LAT-1:0] r_vld;
    logic           accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // valid chain travels alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // stage 1: gamma table lookup
    logic [16:0] r_lin [3];
    always_ff @(posedge i_clk) begin
        r_lin[0] <= rcl_pkg::LIN_ROM[i_pixel.red];
        r_lin[1] <= rcl_pkg::LIN_ROM[i_pixel.green];
        r_lin[2] <= rcl_pkg::LIN_ROM[i_pixel.blue];
    end

    // stage 2: nine matrix products
    logic [36:0] r_prod [3][3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r_prod[i][j] <= 37'(r_lin[j]) * 37'(rcl_pkg::MAT[i][j]);
    end

    // cube root pipe: index k holds the partial root before bit 24-k
    logic [25:0] r_ct [NBITS+1][3];
    logic [24:0] r_cf [NBITS+1][3];
    logic [25:0] r_mt [NBITS][3];
    logic [24:0] r_mf [NBITS][3];
    logic [24:0] r_mc [NBITS][3];
    logic [25:0] r_ms [NBITS][3];

    // stage 3: row sums, rounded to q24 normalised xyz
    logic [38:0] sum [3];
    always_comb begin
        for (int i = 0; i < 3; i++)
            sum[i] = 39'(r_prod[i][0]) + 39'(r_prod[i][1]) + 39'(r_prod[i][2])
                     + 39'd2048;
    end
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_ct[0][i] <= sum[i][37:12];
            r_cf[0][i] <= '0;
        end
    end

    // bit-by-bit root search, two stages per bit so each holds one multiply
    for (genvar k = 0; k < NBITS; k++) begin : g_root
        localparam int BIT = NBITS - 1 - k;
        logic [24:0] cand [3];
        logic [49:0] sq   [3];
        logic [50:0] cube [3];
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                cand[i] = r_cf[k][i] | (25'd1 << BIT);
                sq[i]   = 50'(cand[i]) * 50'(cand[i]);
                cube[i] = 51'(r_ms[k][i]) * 51'(r_mc[k][i]);
            end
        end
        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                r_mt[k][i]   <= r_ct[k][i];
                r_mf[k][i]   <= r_cf[k][i];
                r_mc[k][i]   <= cand[i];
                r_ms[k][i]   <= sq[i][49:24];
                r_ct[k+1][i] <= r_mt[k][i];
                // keep the candidate bit when its truncated cube fits
                r_cf[k+1][i] <= (cube[i][50:24] <= 27'(r_mt[k][i])) ?
                                r_mc[k][i] : r_mf[k][i];
            end
        end
    end

    // linear segment near black: f = (7787 t + 500) / 1000 + 16/116
    logic [38:0] r_lx   [3];
    logic        r_lsel [3];
    logic [24:0] r_lf   [3];
    logic [27:0] r_lq   [3];
    logic        r_lsel2 [3];
    logic [24:0] r_lf2  [3];
    logic [24:0] r_f    [3];
    logic [56:0] qprod  [3];
    always_comb begin
        for (int i = 0; i < 3; i++)
            qprod[i] = 57'(r_lx[i][30:3]) * 57'(rcl_pkg::RECIP_125);
    end
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_lx[i]    <= 39'(r_ct[NBITS][i]) * 39'd7787 + 39'd500;
            r_lsel[i]  <= (48'(r_ct[NBITS][i]) * 48'd1000000) <= 48'(rcl_pkg::LIN_LIMIT);
            r_lf[i]    <= r_cf[NBITS][i];
            r_lq[i]    <= 28'(qprod[i][56:35]) + 28'(rcl_pkg::F_OFFSET);
            r_lsel2[i] <= r_lsel[i];
            r_lf2[i]   <= r_lf[i];
            r_f[i]     <= r_lsel2[i] ? r_lq[i][24:0] : r_lf2[i];
        end
    end

    // output stage 1: scale to q24 l, a and b
    logic signed [39:0] r_lv;
    logic signed [39:0] r_av;
    logic signed [39:0] r_bv;
    logic signed [39:0] fx;
    logic signed [39:0] fy;
    logic signed [39:0] fz;
    always_comb begin
        fx = 40'(r_f[0]);
        fy = 40'(r_f[1]);
        fz = 40'(r_f[2]);
    end
    always_ff @(posedge i_clk) begin
        r_lv <= 40'sd116 * fy - (40'sd16 <<< 24);
        r_av <= 40'sd500 * (fx - fy);
        r_bv <= 40'sd200 * (fy - fz);
    end

    // output stage 2: round half up, then saturate l to 0..L_MAX and a and b to the field limits
    logic signed [39:0] lr;
    logic signed [39:0] ar;
    logic signed [39:0] br;
    rcl_pkg::t_lab      n_lab;
    rcl_pkg::t_lab      r_lab;
    always_comb begin
        lr = (r_lv + (40'sd1 <<< (rcl_pkg::RND_SHIFT - 1))) >>> rcl_pkg::RND_SHIFT;
        ar = (r_av + (40'sd1 <<< (rcl_pkg::RND_SHIFT - 1))) >>> rcl_pkg::RND_SHIFT;
        br = (r_bv + (40'sd1 <<< (rcl_pkg::RND_SHIFT - 1))) >>> rcl_pkg::RND_SHIFT;
        if (lr < 0)                              n_lab.lightness = '0;
        else if (lr > 40'(rcl_pkg::L_MAX))       n_lab.lightness = 15'(rcl_pkg::L_MAX);
        else                                     n_lab.lightness = lr[14:0];
        if (ar < -40'sd32768)                    n_lab.green_red = 16'sh8000;
        else if (ar > 40'sd32767)                n_lab.green_red = 16'sh7fff;
        else                                     n_lab.green_red = ar[15:0];
        if (br < -40'sd32768)                    n_lab.blue_yellow = 16'sh8000;
        else if (br > 40'sd32767)                n_lab.blue_yellow = 16'sh7fff;
        else                                     n_lab.blue_yellow = br[15:0];
    end
    always_ff @(posedge i_clk) begin
        r_lab <= n_lab;
    end

    assign o_valid = r_vld[LAT-1];
    assign o_lab   = r_lab;

    // every accepted beat leaves the pipeline as an o_valid strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_valid)
        else $error("beat did not leave after pipeline latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_vld[LAT-2] == $past(r_vld[LAT-3]))
        else $error("valid chain out of step");

    a_l_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_lab.lightness <= 15'(rcl_pkg::L_MAX))
        else $error("lightness above limit");

endmodule
`default_nettype wire

// ===== sim/tb_rgb_to_cielab_core.sv =====
// tb_rgb_to_cielab_core: self-checking bench for the srgb to cielab d65 converter
// depends on rcl_pkg (pixel and lab types, OUT_FRAC_BITS) and rgb_to_cielab_core
// directed pixel table first, then random pixels, checked against a local predictor or a typed-in answer
`default_nettype none
module tb_rgb_to_cielab_core;

    localparam int LATENCY   = 58;
    localparam int N_RANDOM  = 600;
    localparam int N_TABLE   = 14;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    rcl_pkg::t_pixel  i_pixel;
    logic             o_valid;
    rcl_pkg::t_lab    o_lab;

    rgb_to_cielab_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .o_lab   (o_lab)
    );

    // predictor tables, built at time zero
    longint lin_q16 [256];
    longint coef_q20 [3][3];

    // expected lab values, oldest first
    rcl_pkg::t_lab lab_queue [$];
    int     n_errors;
    int     n_checked;
    bit     idle_free;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint round_div(longint num, longint den);
        return (2 * num + den) / (2 * den);
    endfunction

    // srgb code to linear q16, piecewise curve with a fifth-root search
    function automatic longint srgb_linear(int code);
        longint unsigned u;
        longint unsigned v;
        longint unsigned w;
        longint unsigned cand;
        longint unsigned p;
        longint unsigned one30;
        bit ok;
        one30 = 64'd1 << 30;
        w = 0;
        if (code <= 10) return round_div(longint'(code) * 6553600, 255 * 1292);
        u = round_div((longint'(1000 * code + 14025)) << 30, 269025);
        v = (u * u) >> 30;
        for (int b = 30; b >= 0; b--) begin
            cand = w | (64'd1 << b);
            if (cand <= one30) begin
                p  = cand;
                ok = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    if (ok) begin
                        p = (p * cand) >> 30;
                        if (p > one30) ok = 1'b0;
                    end
                end
                if (ok && p <= v) w = cand;
            end
        end
        return longint'((((v * w) >> 30) + (64'd1 << 13)) >> 14);
    endfunction

    // cielab companding: cube root above the knee, linear segment below
    function automatic longint lab_compand(longint t);
        longint f;
        longint cand;
        f = 0;
        if (t * 1000000 > (longint'(8856) << 24)) begin
            for (int b = 24; b >= 0; b--) begin
                cand = f | (longint'(1) << b);
                if ((((cand * cand) >> 24) * cand) >> 24 <= t) f = cand;
            end
            return f;
        end
        return (7787 * t + 500) / 1000 + round_div(longint'(16) << 24, 116);
    endfunction

    // floor(v / 2^s + 1/2); >>> floors for signed values
    function automatic longint round_q(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic rcl_pkg::t_lab predict_lab(rcl_pkg::t_pixel px);
        longint lin [3];
        longint fv [3];
        longint sum;
        longint lmax;
        int     s;
        rcl_pkg::t_lab r;
        s = 24 - rcl_pkg::OUT_FRAC_BITS;
        lin[0] = lin_q16[px.red];
        lin[1] = lin_q16[px.green];
        lin[2] = lin_q16[px.blue];
        for (int i = 0; i < 3; i++) begin
            sum = lin[0] * coef_q20[i][0] + lin[1] * coef_q20[i][1]
                + lin[2] * coef_q20[i][2];
            fv[i] = lab_compand((sum + 2048) >>> 12);
        end
        lmax = longint'(100) << rcl_pkg::OUT_FRAC_BITS;
        if (lmax > 32767) lmax = 32767;
        r.lightness   = 15'(sat(round_q(116 * fv[1] - (longint'(16) << 24), s), 0, lmax));
        r.green_red   = 16'(sat(round_q(500 * (fv[0] - fv[1]), s), -32768, 32767));
        r.blue_yellow = 16'(sat(round_q(200 * (fv[1] - fv[2]), s), -32768, 32767));
        return r;
    endfunction

    // directed pixels; tbl_known marks rows whose answer is typed in
    rcl_pkg::t_pixel tbl_px   [N_TABLE];
    rcl_pkg::t_lab   tbl_lab  [N_TABLE];
    bit              tbl_known[N_TABLE];

    task automatic fill_table();
        // black: all zero; white: L at full scale, a and b near zero
        tbl_px[0]  = '{8'h00, 8'h00, 8'h00}; tbl_known[0] = 1;
        tbl_lab[0] = '{15'd0, 16'sd0, 16'sd0};
        tbl_px[1]  = '{8'hff, 8'hff, 8'hff}; tbl_known[1] = 0;
        tbl_px[2]  = '{8'hff, 8'h00, 8'h00}; tbl_known[2] = 0;
        tbl_px[3]  = '{8'h00, 8'hff, 8'h00}; tbl_known[3] = 0;
        tbl_px[4]  = '{8'h00, 8'h00, 8'hff}; tbl_known[4] = 0;
        // codes either side of the linear segment of the srgb curve
        tbl_px[5]  = '{8'd10, 8'd10, 8'd10}; tbl_known[5] = 0;
        tbl_px[6]  = '{8'd11, 8'd11, 8'd11}; tbl_known[6] = 0;
        // a dark pixel below the cielab knee, then two greys just above it
        tbl_px[7]  = '{8'd1, 8'd2, 8'd3};    tbl_known[7] = 0;
        tbl_px[8]  = '{8'd24, 8'd24, 8'd24}; tbl_known[8] = 0;
        tbl_px[9]  = '{8'd25, 8'd25, 8'd25}; tbl_known[9] = 0;
        tbl_px[10] = '{8'hff, 8'h00, 8'hff}; tbl_known[10] = 0;
        tbl_px[11] = '{8'h00, 8'hff, 8'hff}; tbl_known[11] = 0;
        tbl_px[12] = '{8'haa, 8'h55, 8'haa}; tbl_known[12] = 0;
        tbl_px[13] = '{8'h55, 8'haa, 8'h55}; tbl_known[13] = 0;
        for (int i = 0; i < N_TABLE; i++)
            if (!tbl_known[i]) tbl_lab[i] = predict_lab(tbl_px[i]);
    endtask

    // one beat: random idle gaps unless idle_free, then hold start until the edge where busy is low
    task automatic send_pixel(rcl_pkg::t_pixel px, rcl_pkg::t_lab want);
        if (!idle_free) begin
            while ($urandom_range(99) < 26) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start   <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        lab_queue.push_back(want);
    endtask

    // result checker, samples at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (lab_queue.size() == 0) begin
                $display("%0t unexpected result %h", $time, o_lab);
                n_errors++;
            end else begin
                rcl_pkg::t_lab want;
                want = lab_queue.pop_front();
                n_checked++;
                if (o_lab.lightness !== want.lightness) begin
                    $display("%0t lightness exp %0d got %0d", $time,
                             want.lightness, o_lab.lightness);
                    n_errors++;
                end
                if (o_lab.green_red !== want.green_red) begin
                    $display("%0t green_red exp %0d got %0d", $time,
                             want.green_red, o_lab.green_red);
                    n_errors++;
                end
                if (o_lab.blue_yellow !== want.blue_yellow) begin
                    $display("%0t blue_yellow exp %0d got %0d", $time,
                             want.blue_yellow, o_lab.blue_yellow);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        rcl_pkg::t_pixel px;
        int     wait_cnt;
        n_errors  = 0;
        n_checked = 0;
        idle_free = 0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_pixel   = '0;
        for (int i = 0; i < 256; i++) lin_q16[i] = srgb_linear(i);
        begin
            longint num [3][3];
            longint den [3];
            num = '{'{41240, 35760, 18050}, '{2126, 7152, 722}, '{1930, 11920, 95050}};
            den = '{95047, 10000, 108883};
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    coef_q20[i][j] = round_div(num[i][j] << 20, den[i]);
        end
        fill_table();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_TABLE; i++) send_pixel(tbl_px[i], tbl_lab[i]);

        // sender holds off until the pipe has drained
        start <= 1'b0;
        @(posedge i_clk);
        while (lab_queue.size() != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            // a stretch at full rate in the middle
            idle_free = (n >= 200 && n < 320);
            case ($urandom_range(3))
                0: px = '{8'($urandom_range(30)), 8'($urandom_range(30)),
                          8'($urandom_range(30))};
                1: px = '{$urandom_range(1) ? 8'hff : 8'h00,
                          $urandom_range(1) ? 8'hff : 8'h00,
                          8'($urandom)};
                default: px = rcl_pkg::t_pixel'(24'($urandom));
            endcase
            send_pixel(px, predict_lab(px));
        end
        start <= 1'b0;

        wait_cnt = 0;
        while (lab_queue.size() != 0 && wait_cnt < 10 * LATENCY) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("%0d pixels sent, %0d lab results checked: extremes, primaries,",
                 N_TABLE + N_RANDOM, n_checked);
        $display("curve and knee edges, dark and random pixels with idle gaps");
        if (n_errors == 0 && lab_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog, far past the slowest correct run
    initial begin
        #200000;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/rcl_pkg.sv
rtl/rgb_to_cielab_core.sv
sim/tb_rgb_to_cielab_core.sv
